// ===== rtl/itf_pkg.sv =====
// shared types and constants of the integer text formatter
package itf_pkg;

  // conversion kinds
  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_LHEX = 2'd2,
    OP_UHEX = 2'd3
  } op_t;

  // digit store: ten digits cover any 32-bit magnitude in decimal or hex
  localparam int MAG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGITS_W   = NUM_DIGITS * 4;
  localparam int NDIG_W     = 4;
  localparam int BITCNT_W   = $clog2(MAG_W);

  // ascii codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  // control handed to the character emitter with the run lengths
  typedef struct packed {
    logic       load;
    logic       left;
    logic       has_sign;
    logic [7:0] sign_char;
    logic       upper;
  } emit_ctrl_t;

endpackage

// ===== rtl/itf_digits.sv =====
// bit-serial binary to digit converter with leading zero strip
module itf_digits (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  itf_pkg::op_t                      op,
  input  logic [itf_pkg::MAG_W-1:0]         mag,
  output logic                              done,
  output logic [itf_pkg::DIGITS_W-1:0]      digits,
  output logic [itf_pkg::NDIG_W-1:0]        ndig
);
  import itf_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_CONV = 3'b010,
    D_NORM = 3'b100
  } dstate_t;

  dstate_t             state;
  logic [MAG_W-1:0]    bin;
  logic [DIGITS_W-1:0] adj;
  logic [BITCNT_W-1:0] bit_cnt;

  // add-3 correction on every decimal digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits[4*i +: 4];
      end
    end
  end

  // conversion sequencer: one input bit per cycle for decimal kinds, then one digit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            if (op == OP_LHEX || op == OP_UHEX) begin
              digits <= {{(DIGITS_W-MAG_W){1'b0}}, mag};
              ndig   <= NDIG_W'(NUM_DIGITS);
              state  <= D_NORM;
            end else begin
              digits  <= '0;
              bin     <= mag;
              bit_cnt <= BITCNT_W'(MAG_W - 1);
              state   <= D_CONV;
            end
          end
        end
        D_CONV: begin
          digits <= {adj[DIGITS_W-2:0], bin[MAG_W-1]};
          bin    <= {bin[MAG_W-2:0], 1'b0};
          if (bit_cnt == '0) begin
            ndig  <= NDIG_W'(NUM_DIGITS);
            state <= D_NORM;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        D_NORM: begin
          if (digits[DIGITS_W-1 -: 4] == 4'd0 && ndig > NDIG_W'(1)) begin
            digits <= {digits[DIGITS_W-5:0], 4'd0};
            ndig   <= ndig - 1'b1;
          end else begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/itf_emit.sv =====
// character emitter: pads, sign, zeros and digits one character per cycle
module itf_emit #(
  parameter int CW = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  itf_pkg::emit_ctrl_t           ctrl,
  input  logic [CW-1:0]                 spaces,
  input  logic [CW-1:0]                 zeros,
  input  logic [itf_pkg::NDIG_W-1:0]    ndig,
  input  logic [itf_pkg::DIGITS_W-1:0]  digits,
  output logic [7:0]                    char_code,
  output logic                          is_last,
  output logic                          strobe
);
  import itf_pkg::*;

  logic [CW-1:0]       total;
  logic [CW-1:0]       sp_cnt;
  logic [CW-1:0]       zr_cnt;
  logic [NDIG_W-1:0]   dg_cnt;
  logic                sign_pend;
  logic [7:0]          sign_char;
  logic                left;
  logic                upper;
  logic [DIGITS_W-1:0] dig_sr;
  logic [3:0]          nib;
  logic [7:0]          dig_char;

  // top digit to ascii
  assign nib = dig_sr[DIGITS_W-1 -: 4];
  always_comb begin
    if (nib < 4'd10) begin
      dig_char = CH_ZERO + {4'd0, nib};
    end else if (upper) begin
      dig_char = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end else begin
      dig_char = CH_LOWER_A + {4'd0, nib} - 8'd10;
    end
  end

  // run counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      strobe <= 1'b0;
      is_last <= 1'b0;
    end else if (ctrl.load) begin
      strobe    <= 1'b0;
      total     <= spaces + zeros + CW'(ndig) + CW'(ctrl.has_sign);
      sp_cnt    <= spaces;
      zr_cnt    <= zeros;
      dg_cnt    <= ndig;
      sign_pend <= ctrl.has_sign;
      sign_char <= ctrl.sign_char;
      left      <= ctrl.left;
      upper     <= ctrl.upper;
      dig_sr    <= digits;
    end else if (total != '0) begin
      strobe  <= 1'b1;
      is_last <= (total == CW'(1));
      total   <= total - 1'b1;
      if (!left && sp_cnt != '0) begin
        char_code <= CH_SPACE;
        sp_cnt    <= sp_cnt - 1'b1;
      end else if (sign_pend) begin
        char_code <= sign_char;
        sign_pend <= 1'b0;
      end else if (zr_cnt != '0) begin
        char_code <= CH_ZERO;
        zr_cnt    <= zr_cnt - 1'b1;
      end else if (dg_cnt != '0) begin
        char_code <= dig_char;
        dg_cnt    <= dg_cnt - 1'b1;
        dig_sr    <= {dig_sr[DIGITS_W-5:0], 4'd0};
      end else begin
        char_code <= CH_SPACE;
        sp_cnt    <= sp_cnt - 1'b1;
      end
    end else begin
      strobe  <= 1'b0;
      is_last <= 1'b0;
    end
  end

endmodule

// ===== rtl/integer_text_formatter_top.sv =====
// top level of the integer text formatter
//
// Formats one decoded printf integer conversion (%d, %u, %x, %X with width,
// precision and the left, zero, plus and space flags) as ASCII characters.
// Command channel: a conversion is taken at a clock edge where start is high
// and busy is low; busy then stays high until the last character is out.
// Result channel: each character is on char_code for exactly one cycle with
// strobe high; is_last marks the final character of the field. The receiver
// cannot stall, so characters stream at one per cycle.
// Sequence: decimal kinds pass through the bit-serial binary to digit
// converter, hex kinds skip it; then up to 9 leading zero digits are
// stripped, one digit per cycle. The converter's done register, the emitter's
// load of the run lengths and its output register lie between the last strip
// and the first character; the field (up to MAX_WIDTH or MAX_PRECISION + 1
// characters) then streams at one per cycle. busy drops in the cycle after
// the last character; the next command is taken at the edge that ends the
// first idle cycle. Reset clears all sequencing; no character is shown after
// reset until a new command is taken.
module integer_text_formatter_top #(
  parameter int MAX_WIDTH     = 48,
  parameter int MAX_PRECISION = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [31:0]       value,
  input  logic [5:0]        field_width,
  input  logic signed [6:0] precision,
  input  logic              left_align,
  input  logic              zero_fill,
  input  logic              force_plus,
  input  logic              space_sign,
  output logic [7:0]        char_code,
  output logic              is_last,
  output logic              strobe
);
  import itf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + MAX_PRECISION + 2);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIGITS = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t              state;
  logic                accept;
  op_t                 op_in;
  logic [MAG_W-1:0]    mag;
  logic [6:0]          fw_ext;
  logic [6:0]          pr_ext;

  // captured command
  logic                is_sdec;
  logic                left;
  logic                zfill;
  logic                pv;
  logic [CW-1:0]       w_c;
  logic [CW-1:0]       p_c;
  logic                has_sign;
  logic [7:0]          sign_char;
  logic                upper;

  // converter outputs
  logic                dig_done;
  logic [DIGITS_W-1:0] dig_val;
  logic [NDIG_W-1:0]   dig_ndig;

  // layout
  logic [CW-1:0]       nd;
  logic [CW-1:0]       zeros0;
  logic [CW-1:0]       field0;
  logic [CW-1:0]       zeros;
  logic [CW-1:0]       spaces;
  emit_ctrl_t          ctrl;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign op_in  = op_t'(op);
  assign fw_ext = {1'b0, field_width};
  assign pr_ext = {1'b0, precision[5:0]};

  // magnitude of the operand, negated for negative signed values
  assign mag = (op_in == OP_SDEC && value[MAG_W-1]) ? (~value + 1'b1) : value;

  // command capture with clamping and sign selection
  always_ff @(posedge clk) begin
    if (accept) begin
      is_sdec <= (op_in == OP_SDEC);
      upper   <= (op_in == OP_UHEX);
      left    <= left_align;
      zfill   <= zero_fill;
      w_c     <= (fw_ext > 7'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_ext);
      pv      <= !precision[6];
      p_c     <= (pr_ext > 7'(MAX_PRECISION)) ? CW'(MAX_PRECISION) : CW'(pr_ext);
      has_sign  <= 1'b0;
      sign_char <= CH_SPACE;
      if (op_in == OP_SDEC) begin
        if (value[MAG_W-1]) begin
          has_sign  <= 1'b1;
          sign_char <= CH_MINUS;
        end else if (force_plus) begin
          has_sign  <= 1'b1;
          sign_char <= CH_PLUS;
        end else if (space_sign) begin
          has_sign  <= 1'b1;
          sign_char <= CH_SPACE;
        end
      end
    end
  end

  // zero and space run lengths once the digit count is known
  always_comb begin
    nd     = CW'(dig_ndig);
    zeros0 = (pv && p_c > nd) ? (p_c - nd) : '0;
    field0 = nd + zeros0 + CW'(has_sign);
    if (is_sdec) begin
      if (!pv && zfill && !left && w_c > field0) begin
        zeros  = zeros0 + (w_c - field0);
        spaces = '0;
      end else begin
        zeros  = zeros0;
        spaces = (w_c > field0) ? (w_c - field0) : '0;
      end
    end else begin
      if (!pv && zfill && w_c > nd) begin
        zeros = w_c - nd;
      end else begin
        zeros = zeros0;
      end
      spaces = (w_c > nd + zeros) ? (w_c - nd - zeros) : '0;
    end
  end

  assign ctrl.load      = (state == S_DIGITS) && dig_done;
  assign ctrl.left      = left;
  assign ctrl.has_sign  = has_sign;
  assign ctrl.sign_char = sign_char;
  assign ctrl.upper     = upper;

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (accept) state <= S_DIGITS;
        S_DIGITS: if (dig_done) state <= S_EMIT;
        S_EMIT:   if (strobe && is_last) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  itf_digits u_digits (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .op     (op_in),
    .mag    (mag),
    .done   (dig_done),
    .digits (dig_val),
    .ndig   (dig_ndig)
  );

  itf_emit #(
    .CW (CW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .spaces    (spaces),
    .zeros     (zeros),
    .ndig      (dig_ndig),
    .digits    (dig_val),
    .char_code (char_code),
    .is_last   (is_last),
    .strobe    (strobe)
  );

  // a taken command keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not raised after command transfer");

  // characters only flow while a conversion is in progress
  a_strobe_in_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (state == S_EMIT)) else $error("character strobe outside emit phase");

  // the last character releases the block
  a_release_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && is_last |=> !busy) else $error("busy held after last character");

  // converter finishes only while the sequencer waits for it
  a_done_in_digits: assert property (@(posedge clk) disable iff (rst)
    dig_done |-> (state == S_DIGITS)) else $error("digit converter done while not waited on");

endmodule

// ===== tb/sv/itf_char_checker.sv =====
// checker for the integer text formatter: predicts each field and compares the character stream
`timescale 1ns / 100ps

module itf_char_checker #(
  parameter int MAX_WIDTH     = 48,
  parameter int MAX_PRECISION = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        op,
  input  logic [31:0]       value,
  input  logic [5:0]        field_width,
  input  logic signed [6:0] precision,
  input  logic              left_align,
  input  logic              zero_fill,
  input  logic              force_plus,
  input  logic              space_sign,
  input  logic [7:0]        char_code,
  input  logic              is_last,
  input  logic              strobe,
  output int                mismatch_count,
  output int                pending_count
);
  import itf_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } field_char_t;

  // characters still owed by the formatter, oldest first
  field_char_t expected_chars[$];
  int          error_total = 0;

  function automatic void log_error(input string msg);
    error_total++;
    if (error_total <= 10) $display("mismatch: %s", msg);
  endfunction

  // build the formatted field of one conversion and queue its characters
  function automatic void predict_field(input logic [1:0] kind_raw, input logic [31:0] val,
                                        input logic [5:0] fw, input logic signed [6:0] pr,
                                        input logic la, input logic zf, input logic fp,
                                        input logic ss);
    op_t         kind;
    int          width;
    int          prec;
    int          ndig;
    int          zeros;
    int          spaces;
    int          field_len;
    int unsigned base;
    logic [31:0] mag;
    logic [31:0] d;
    logic [7:0]  sign_ch;
    logic [7:0]  alpha;
    logic [7:0]  digs[16];
    logic [7:0]  line[$];
    field_char_t fc;
    kind    = op_t'(kind_raw);
    width   = (int'(fw) > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
    prec    = int'(pr);
    if (prec < 0) prec = -1;
    if (prec > MAX_PRECISION) prec = MAX_PRECISION;
    base    = (kind == OP_SDEC || kind == OP_UDEC) ? 10 : 16;
    alpha   = (kind == OP_UHEX) ? CH_UPPER_A : CH_LOWER_A;
    mag     = val;
    sign_ch = 8'h00;

    // sign only for signed decimal
    if (kind == OP_SDEC) begin
      if (val[31]) begin
        sign_ch = CH_MINUS;
        mag     = 32'd0 - val;
      end else if (fp) begin
        sign_ch = CH_PLUS;
      end else if (ss) begin
        sign_ch = CH_SPACE;
      end
    end

    // digits, least significant first; zero still gives one digit
    ndig = 0;
    do begin
      d          = mag % base;
      digs[ndig] = (d < 10) ? CH_ZERO + d[7:0] : alpha + d[7:0] - 8'd10;
      ndig++;
      mag = mag / base;
    end while (mag != 0);

    zeros = (prec > ndig) ? prec - ndig : 0;
    if (kind == OP_SDEC) begin
      field_len = ndig + zeros + ((sign_ch != 8'h00) ? 1 : 0);
      if (prec < 0 && zf && !la && width > field_len) begin
        zeros     += width - field_len;
        field_len  = width;
      end
      spaces = (width > field_len) ? width - field_len : 0;
    end else begin
      // zero fill by width applies here even when left-aligned
      if (prec < 0 && zf && width > ndig) zeros = width - ndig;
      spaces = width - ndig - zeros;
      if (spaces < 0) spaces = 0;
    end

    if (!la) repeat (spaces) line.push_back(CH_SPACE);
    if (sign_ch != 8'h00) line.push_back(sign_ch);
    repeat (zeros) line.push_back(CH_ZERO);
    for (int k = ndig - 1; k >= 0; k--) line.push_back(digs[k]);
    if (la) repeat (spaces) line.push_back(CH_SPACE);

    foreach (line[i]) begin
      fc.code = line[i];
      fc.last = (i == line.size() - 1);
      expected_chars.push_back(fc);
    end
  endfunction

  // predict on each command transfer, compare on each character transfer
  always @(posedge clk) begin
    field_char_t want;
    if (!rst) begin
      if (start && !busy)
        predict_field(op, value, field_width, precision, left_align, zero_fill,
                      force_plus, space_sign);
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          log_error($sformatf("unexpected character %h is_last %b", char_code, is_last));
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code || is_last !== want.last)
            log_error($sformatf("char_code exp %h got %h, is_last exp %b got %b",
                                want.code, char_code, want.last, is_last));
        end
      end
    end
    mismatch_count <= error_total;
    pending_count  <= expected_chars.size();
  end

endmodule

// ===== tb/sv/integer_text_formatter_top_test.sv =====
// testbench top for the integer text formatter: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module integer_text_formatter_top_test;
  import itf_pkg::*;

  localparam int MAX_WIDTH     = 48;
  localparam int MAX_PRECISION = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 360;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        op = OP_SDEC;
  logic [31:0]       value = '0;
  logic [5:0]        field_width = '0;
  logic signed [6:0] precision = -7'sd1;
  logic              left_align = 1'b0;
  logic              zero_fill = 1'b0;
  logic              force_plus = 1'b0;
  logic              space_sign = 1'b0;
  logic [7:0]        char_code;
  logic              is_last;
  logic              strobe;
  int                mismatch_count;
  int                pending_count;
  int                cycle_count = 0;
  logic              gaps_on = 1'b0;

  always #6 clk = ~clk;

  integer_text_formatter_top #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_PRECISION(MAX_PRECISION)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .value      (value),
    .field_width(field_width),
    .precision  (precision),
    .left_align (left_align),
    .zero_fill  (zero_fill),
    .force_plus (force_plus),
    .space_sign (space_sign),
    .char_code  (char_code),
    .is_last    (is_last),
    .strobe     (strobe)
  );

  itf_char_checker #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_PRECISION(MAX_PRECISION)
  ) checker_inst (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .value         (value),
    .field_width   (field_width),
    .precision     (precision),
    .left_align    (left_align),
    .zero_fill     (zero_fill),
    .force_plus    (force_plus),
    .space_sign    (space_sign),
    .char_code     (char_code),
    .is_last       (is_last),
    .strobe        (strobe),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL integer_text_formatter_top");
      $finish;
    end
  end

  // one command transfer, with an optional idle gap after the block frees up
  task automatic send_conversion(input op_t kind, input logic [31:0] val, input logic [5:0] fw,
                                 input logic signed [6:0] pr, input logic la, input logic zf,
                                 input logic fp, input logic ss);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    op          <= kind;
    value       <= val;
    field_width <= fw;
    precision   <= pr;
    left_align  <= la;
    zero_fill   <= zf;
    force_plus  <= fp;
    space_sign  <= ss;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [31:0]       rv;
    logic [5:0]        rw;
    logic signed [6:0] rp;
    logic [3:0]        rf;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero values, extremes, flag interplay and clamping
    send_conversion(OP_SDEC, 32'd0, 6'd0, 7'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_SDEC, 32'h8000_0000, 6'd0, -7'sd1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_SDEC, 32'h7FFF_FFFF, 6'd0, -7'sd1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_conversion(OP_SDEC, 32'd5, 6'd4, -7'sd1, 1'b0, 1'b0, 1'b0, 1'b1);
    send_conversion(OP_SDEC, 32'd5, 6'd4, -7'sd1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_conversion(OP_SDEC, -32'sd42, 6'd10, -7'sd1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_SDEC, -32'sd42, 6'd10, -7'sd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_SDEC, 32'd123, 6'd8, 7'sd5, 1'b0, 1'b1, 1'b1, 1'b0);
    send_conversion(OP_SDEC, 32'hFFFF_FFFF, 6'd48, 7'sd32, 1'b0, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_SDEC, 32'd9, 6'd63, 7'sd63, 1'b1, 1'b0, 1'b0, 1'b1);
    send_conversion(OP_UDEC, 32'hFFFF_FFFF, 6'd63, -7'sd1, 1'b0, 1'b0, 1'b1, 1'b1);
    send_conversion(OP_UDEC, 32'd7, 6'd12, -7'sd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_UDEC, 32'd0, 6'd48, 7'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_UDEC, 32'd1000, 6'd6, 7'sd2, 1'b0, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_LHEX, 32'hDEAD_BEEF, 6'd0, 7'sd63, 1'b0, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_LHEX, 32'hFFFF_FFFF, 6'd63, -7'sd1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_LHEX, 32'h0000_00AB, 6'd9, -7'sd1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_conversion(OP_UHEX, 32'hABCD_EF01, 6'd20, -7'sd64, 1'b0, 1'b1, 1'b0, 1'b0);
    send_conversion(OP_UHEX, 32'd0, 6'd0, 7'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_conversion(OP_UHEX, 32'h1234_5678, 6'd16, 7'sd12, 1'b1, 1'b1, 1'b1, 1'b0);
    send_conversion(OP_SDEC, 32'hFFFF_FFD6, 6'd12, -7'sd5, 1'b0, 1'b1, 1'b0, 1'b1);

    // random conversions, gaps switched on and off in stretches
    gaps_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 29) == 0) gaps_on = ~gaps_on;
      case ($urandom_range(0, 4))
        0: rv = $urandom_range(0, 20);
        1: rv = 32'hFFFF_FFFF - $urandom_range(0, 20);
        2: rv = 32'h8000_0000 ^ $urandom_range(0, 20);
        3: rv = $urandom >> $urandom_range(0, 31);
        default: rv = $urandom;
      endcase
      rw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 16));
      case ($urandom_range(0, 3))
        0, 1: rp = -7'sd1;
        2: rp = 7'($urandom_range(0, 12));
        default: rp = 7'($urandom_range(0, 127));
      endcase
      rf = 4'($urandom_range(0, 15));
      send_conversion(op_t'($urandom_range(0, 3)), rv, rw, rp, rf[0], rf[1], rf[2], rf[3]);
    end
    start <= 1'b0;

    // drain, then allow for any stray characters
    @(posedge clk);
    wait (pending_count == 0);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("PASS integer_text_formatter_top");
    else
      $display("FAIL integer_text_formatter_top");
    $finish;
  end

endmodule
